>>> rtl/rbed_pkg.sv
// Shared types, constants and register codes for the road bump event detector.
package rbed_pkg;

  localparam int unsigned RAW_W = 12;
  localparam int unsigned MV_W = 12;
  localparam int unsigned GAIN_W = 15;
  localparam int unsigned CNT_W = 16;
  localparam int unsigned MV_FULL_SCALE = 3300;
  localparam int unsigned ADC_FULL_SCALE = 4095;
  localparam int unsigned PROD_W = 24;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTH_GAIN = 3'd0,
    REG_START_TH    = 3'd1,
    REG_SETTLE_TH   = 3'd2,
    REG_SETTLE_HOLD = 3'd3,
    REG_EVENT_MAX   = 3'd4,
    REG_NOISE_FLOOR = 3'd5,
    REG_LEVEL_ONE   = 3'd6,
    REG_LEVEL_TWO   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [GAIN_W-1:0] smooth_gain;
    logic [MV_W-1:0]   start_th;
    logic [MV_W-1:0]   settle_th;
    logic [CNT_W-1:0]  settle_hold;
    logic [CNT_W-1:0]  event_max;
    logic [MV_W-1:0]   noise_floor;
    logic [MV_W-1:0]   level_one;
    logic [MV_W-1:0]   level_two;
  } cfg_t;

  localparam logic [GAIN_W-1:0] SMOOTH_GAIN_RST = 15'd6554;
  localparam logic [MV_W-1:0]   START_TH_RST    = 12'd250;
  localparam logic [MV_W-1:0]   SETTLE_TH_RST   = 12'd150;
  localparam logic [CNT_W-1:0]  SETTLE_HOLD_RST = 16'd600;
  localparam logic [CNT_W-1:0]  EVENT_MAX_RST   = 16'd2000;
  localparam logic [MV_W-1:0]   NOISE_FLOOR_RST = 12'd250;
  localparam logic [MV_W-1:0]   LEVEL_ONE_RST   = 12'd500;
  localparam logic [MV_W-1:0]   LEVEL_TWO_RST   = 12'd900;

  typedef enum logic [1:0] {
    ACQ_SUM,
    ACQ_DIV,
    ACQ_RUN
  } acq_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRACK,
    PH_WAIT,
    PH_REFR
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_POT,
    KIND_BUMP
  } kind_t;

endpackage

>>> rtl/rbed_channels.sv
// Handshake channel interfaces for samples, configuration writes and reports.
interface rbed_sample_if import rbed_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_sample;
  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

interface rbed_cfg_if import rbed_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

interface rbed_report_if import rbed_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             event_kind;
  logic [1:0]       severity;
  logic [MV_W-1:0]  peak_mv;
  logic [CNT_W-1:0] event_width;
  modport source (output valid, output event_kind, output severity, output peak_mv,
                  output event_width, input ready);
  modport sink (input valid, input event_kind, input severity, input peak_mv,
                input event_width, output ready);
endinterface

>>> rtl/rbed_front.sv
// Front end: accepts converter samples and scales them to millivolts.
module rbed_front import rbed_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  rbed_sample_if.sink     sample,
  output logic            push,
  output logic [MV_W-1:0] push_mv,
  input  logic            full
);

  localparam int unsigned SH = $clog2(ADC_FULL_SCALE + 1);
  localparam int unsigned EST_W = PROD_W + 1 - SH;

  logic              prod_valid;
  logic [PROD_W-1:0] prod;
  logic [PROD_W:0]   acc;
  logic [EST_W-1:0]  est;
  logic [PROD_W:0]   est_scaled;
  logic [PROD_W:0]   rem;

  assign sample.ready = !prod_valid || !full;
  assign push = prod_valid && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (sample.ready) begin
      prod_valid <= sample.valid;
    end
    if (sample.valid && sample.ready) begin
      prod <= PROD_W'(sample.raw_sample) * PROD_W'(MV_FULL_SCALE);
    end
  end

  // The full scale is one below a power of two, so the estimate is low by at most one.
  always_comb begin
    acc = {1'b0, prod} + (PROD_W + 1)'(prod[PROD_W-1:SH]);
    est = acc[PROD_W:SH];
    est_scaled = {est, SH'(0)} - (PROD_W + 1)'(est);
    rem = {1'b0, prod} - est_scaled;
    if (rem >= (PROD_W + 1)'(ADC_FULL_SCALE)) begin
      push_mv = est[MV_W-1:0] + MV_W'(1);
    end else begin
      push_mv = est[MV_W-1:0];
    end
  end

endmodule

>>> rtl/rbed_fifo.sv
// Small register queue between the front end and the back end.
module rbed_fifo #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]  mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [FILL_W-1:0] fill;

  assign full = fill == FILL_W'(DEPTH);
  assign empty = fill == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + FILL_W'(1);
      end else if (pop && !push) begin
        fill <= fill - FILL_W'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

>>> rtl/rbed_smooth.sv
// Baseline acquisition with a reciprocal divider, then the exponential smoother.
module rbed_smooth import rbed_pkg::*; #(
  parameter int unsigned BASELINE_COUNT = 200
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [GAIN_W-1:0] gain,
  input  logic              in_valid,
  input  logic [MV_W-1:0]   in_mv,
  output logic              in_pop,
  output logic              out_valid,
  output logic [MV_W-1:0]   out_mv,
  input  logic              out_take,
  output logic [MV_W-1:0]   baseline_mv
);

  localparam int unsigned NUM_W = $clog2(BASELINE_COUNT + 1);
  localparam int unsigned SUM_W = $clog2(BASELINE_COUNT * MV_FULL_SCALE + 1);
  localparam int unsigned DIV_SH = SUM_W + $clog2(BASELINE_COUNT);
  localparam int unsigned RECIP_W = SUM_W + 2;
  localparam int unsigned QPROD_W = SUM_W + RECIP_W;
  // The reciprocal is rounded up with enough fraction bits to be exact for every sum.
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << DIV_SH) + 64'(BASELINE_COUNT) - 64'd1) / 64'(BASELINE_COUNT);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
  localparam int unsigned PRODS_W = MV_W + 1 + GAIN_W + 1;
  localparam logic [NUM_W-1:0] BASE_N = NUM_W'(BASELINE_COUNT);

  acq_t                     acq;
  acq_t                     acq_next;
  logic [NUM_W-1:0]         count;
  logic [NUM_W-1:0]         count_inc;
  logic [SUM_W-1:0]         sum;
  logic [QPROD_W-1:0]       quot_prod;
  logic [MV_W-1:0]          quot;
  logic signed [MV_W:0]     diff;
  logic signed [PRODS_W-1:0] prod;
  logic signed [MV_W+1:0]   step;
  logic signed [MV_W+1:0]   s_sum;

  assign count_inc = count + NUM_W'(1);
  assign quot_prod = QPROD_W'(sum) * QPROD_W'(RECIP);
  assign quot = quot_prod[DIV_SH +: MV_W];

  always_comb begin
    diff = $signed({1'b0, in_mv}) - $signed({1'b0, out_mv});
    prod = diff * $signed({1'b0, gain});
    step = prod[PRODS_W-1:GAIN_W];
    s_sum = $signed({2'b00, out_mv}) + step;
  end

  always_comb begin
    acq_next = acq;
    unique case (acq)
      ACQ_SUM: begin
        if (in_valid && count_inc == BASE_N) begin
          acq_next = ACQ_DIV;
        end
      end
      ACQ_DIV: acq_next = ACQ_RUN;
      ACQ_RUN: acq_next = ACQ_RUN;
      default: acq_next = ACQ_SUM;
    endcase
  end

  always_comb begin
    unique case (acq)
      ACQ_SUM: in_pop = in_valid;
      ACQ_RUN: in_pop = in_valid && (!out_valid || out_take);
      default: in_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acq <= ACQ_SUM;
      count <= '0;
      sum <= '0;
      out_valid <= 1'b0;
    end else begin
      acq <= acq_next;
      unique case (acq)
        ACQ_SUM: begin
          if (in_valid) begin
            sum <= sum + SUM_W'(in_mv);
            count <= count_inc;
          end
        end
        ACQ_DIV: begin
          baseline_mv <= quot;
          out_mv <= quot;
        end
        ACQ_RUN: begin
          if (in_pop) begin
            out_mv <= s_sum[MV_W-1:0];
            out_valid <= 1'b1;
          end else if (out_take) begin
            out_valid <= 1'b0;
          end
        end
        default: out_valid <= 1'b0;
      endcase
    end
  end

endmodule

>>> rtl/rbed_tracker.sv
// Event state machine and report register.
module rbed_tracker import rbed_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic [MV_W-1:0] baseline_mv,
  input  logic            in_valid,
  input  logic [MV_W-1:0] in_mv,
  output logic            in_take,
  rbed_report_if.source   report
);

  phase_t           phase;
  phase_t           phase_next;
  kind_t            kind;
  kind_t            kind_next;
  logic [MV_W-1:0]  peak;
  logic [MV_W-1:0]  peak_next;
  logic [CNT_W-1:0] length;
  logic [CNT_W-1:0] length_next;
  logic [CNT_W-1:0] run;
  logic [CNT_W-1:0] run_next;
  logic [CNT_W-1:0] quiet;
  logic [CNT_W-1:0] quiet_next;
  logic [CNT_W-1:0] captured;
  logic [CNT_W-1:0] captured_next;

  logic signed [MV_W:0] dev;
  logic signed [MV_W:0] st;
  logic signed [MV_W:0] tt;
  logic signed [MV_W:0] dev_neg;
  logic [MV_W-1:0]      mag;
  logic                 below;
  logic                 above;
  logic                 settled;
  logic                 raise;
  logic [CNT_W-1:0]     length_inc;
  logic [CNT_W-1:0]     run_inc;
  logic [CNT_W-1:0]     quiet_inc;
  logic [1:0]           sev;
  logic                 done_wait;
  logic                 emit_want;

  logic             rep_valid;
  logic             rep_kind;
  logic [1:0]       rep_sev;
  logic [MV_W-1:0]  rep_peak;
  logic [CNT_W-1:0] rep_width;

  always_comb begin
    dev = $signed({1'b0, in_mv}) - $signed({1'b0, baseline_mv});
    st = $signed({1'b0, cfg.start_th});
    tt = $signed({1'b0, cfg.settle_th});
    dev_neg = -dev;
    mag = dev[MV_W] ? dev_neg[MV_W-1:0] : dev[MV_W-1:0];
    below = dev < -st;
    above = dev > st;
    settled = (dev < tt) && (dev > -tt);
    raise = mag > peak;
    length_inc = length + CNT_W'(1);
    run_inc = run + CNT_W'(1);
    quiet_inc = quiet + CNT_W'(1);
    priority if (peak <= cfg.noise_floor) begin
      sev = 2'd0;
    end else if (peak <= cfg.level_one) begin
      sev = 2'd1;
    end else if (peak <= cfg.level_two) begin
      sev = 2'd2;
    end else begin
      sev = 2'd3;
    end
    done_wait = (phase == PH_WAIT) && settled && (run_inc >= cfg.settle_hold);
    emit_want = done_wait && ((kind == KIND_BUMP) || ((kind == KIND_POT) && (sev != 2'd0)));
    in_take = in_valid && (!emit_want || !rep_valid || report.ready);
  end

  always_comb begin
    phase_next = phase;
    if (in_take) begin
      unique case (phase)
        PH_IDLE: begin
          if (below || above) begin
            phase_next = PH_TRACK;
          end
        end
        PH_TRACK: begin
          if (settled || length_inc >= cfg.event_max) begin
            phase_next = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (done_wait) begin
            phase_next = PH_REFR;
          end
        end
        PH_REFR: begin
          if (settled && quiet_inc >= cfg.settle_hold) begin
            phase_next = PH_IDLE;
          end
        end
      endcase
    end
  end

  always_comb begin
    kind_next = kind;
    peak_next = peak;
    length_next = length;
    run_next = run;
    quiet_next = quiet;
    captured_next = captured;
    if (in_take) begin
      unique case (phase)
        PH_IDLE: begin
          if (below || above) begin
            kind_next = below ? KIND_POT : KIND_BUMP;
            peak_next = mag;
            length_next = '0;
            run_next = '0;
          end
        end
        PH_TRACK: begin
          length_next = length_inc;
          if (((kind == KIND_POT && dev < 0) || (kind == KIND_BUMP && dev > 0)) && raise) begin
            peak_next = mag;
          end
          if (settled || length_inc >= cfg.event_max) begin
            captured_next = length_inc;
            run_next = '0;
          end
        end
        PH_WAIT: begin
          if (settled) begin
            run_next = run_inc;
            if (done_wait) begin
              quiet_next = '0;
              kind_next = KIND_NONE;
              peak_next = '0;
              length_next = '0;
              run_next = '0;
              captured_next = '0;
            end
          end else begin
            run_next = '0;
            if (((kind == KIND_POT && below) || (kind == KIND_BUMP && above)) && raise) begin
              peak_next = mag;
            end
          end
        end
        PH_REFR: begin
          if (settled) begin
            quiet_next = (quiet_inc >= cfg.settle_hold) ? '0 : quiet_inc;
          end else begin
            quiet_next = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      kind <= KIND_NONE;
      peak <= '0;
      length <= '0;
      run <= '0;
      quiet <= '0;
      captured <= '0;
      rep_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      kind <= kind_next;
      peak <= peak_next;
      length <= length_next;
      run <= run_next;
      quiet <= quiet_next;
      captured <= captured_next;
      if (in_take && emit_want) begin
        rep_valid <= 1'b1;
      end else if (report.ready) begin
        rep_valid <= 1'b0;
      end
    end
    if (in_take && emit_want) begin
      rep_kind <= kind == KIND_BUMP;
      rep_sev <= (kind == KIND_BUMP) ? 2'd0 : sev;
      rep_peak <= peak;
      rep_width <= captured;
    end
  end

  assign report.valid = rep_valid;
  assign report.event_kind = rep_kind;
  assign report.severity = rep_sev;
  assign report.peak_mv = rep_peak;
  assign report.event_width = rep_width;

endmodule

>>> rtl/road_bump_event_detector_unit.sv
// Top level of the road bump event detector with its configuration registers.
//
// Samples arrive on the sample channel, one 12-bit converter result per request.
// Reports leave on the report channel: kind, severity, peak in millivolts and width.
// Registers are written on the cfg channel, which is always ready; index selects one
// of eight registers and a write is meant to happen only while the block is idle.
// The block takes one sample per cycle unless the queue is full. A front stage
// scales each sample to millivolts and a four-entry queue feeds the back end, so
// either side can stall. After the first BASELINE_COUNT samples the back end turns
// the sum into the baseline in a single state with a reciprocal multiply and takes
// no sample in that state; the queue absorbs it.
// A report becomes valid once the sample that completes it has passed the front product
// register, the queue, the smoother output register and the report register.
// When the receiver stalls, the report register holds; the back end keeps working
// until it needs to produce another report, then waits.
// Reset is synchronous and active high; it restores the register defaults and
// restarts baseline acquisition.
module road_bump_event_detector_unit import rbed_pkg::*; #(
  parameter int unsigned BASELINE_COUNT = 200
) (
  input  logic          clk,
  input  logic          rst,
  rbed_sample_if.sink   sample,
  rbed_cfg_if.sink      cfg,
  rbed_report_if.source report
);

  cfg_t            cfg_regs;
  logic            q_push;
  logic [MV_W-1:0] q_push_mv;
  logic            q_full;
  logic            q_pop;
  logic [MV_W-1:0] q_pop_mv;
  logic            q_empty;
  logic            s_valid;
  logic [MV_W-1:0] s_mv;
  logic            s_take;
  logic [MV_W-1:0] baseline_mv;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.smooth_gain <= SMOOTH_GAIN_RST;
      cfg_regs.start_th <= START_TH_RST;
      cfg_regs.settle_th <= SETTLE_TH_RST;
      cfg_regs.settle_hold <= SETTLE_HOLD_RST;
      cfg_regs.event_max <= EVENT_MAX_RST;
      cfg_regs.noise_floor <= NOISE_FLOOR_RST;
      cfg_regs.level_one <= LEVEL_ONE_RST;
      cfg_regs.level_two <= LEVEL_TWO_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_SMOOTH_GAIN: cfg_regs.smooth_gain <= cfg.data[GAIN_W-1:0];
        REG_START_TH:    cfg_regs.start_th <= cfg.data[MV_W-1:0];
        REG_SETTLE_TH:   cfg_regs.settle_th <= cfg.data[MV_W-1:0];
        REG_SETTLE_HOLD: cfg_regs.settle_hold <= cfg.data[CNT_W-1:0];
        REG_EVENT_MAX:   cfg_regs.event_max <= cfg.data[CNT_W-1:0];
        REG_NOISE_FLOOR: cfg_regs.noise_floor <= cfg.data[MV_W-1:0];
        REG_LEVEL_ONE:   cfg_regs.level_one <= cfg.data[MV_W-1:0];
        REG_LEVEL_TWO:   cfg_regs.level_two <= cfg.data[MV_W-1:0];
      endcase
    end
  end

  rbed_front u_front (
    .clk     (clk),
    .rst     (rst),
    .sample  (sample),
    .push    (q_push),
    .push_mv (q_push_mv),
    .full    (q_full)
  );

  rbed_fifo #(
    .WIDTH (MV_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_mv),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_mv),
    .empty     (q_empty)
  );

  rbed_smooth #(
    .BASELINE_COUNT (BASELINE_COUNT)
  ) u_smooth (
    .clk         (clk),
    .rst         (rst),
    .gain        (cfg_regs.smooth_gain),
    .in_valid    (!q_empty),
    .in_mv       (q_pop_mv),
    .in_pop      (q_pop),
    .out_valid   (s_valid),
    .out_mv      (s_mv),
    .out_take    (s_take),
    .baseline_mv (baseline_mv)
  );

  rbed_tracker u_tracker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_regs),
    .baseline_mv (baseline_mv),
    .in_valid    (s_valid),
    .in_mv       (s_mv),
    .in_take     (s_take),
    .report      (report)
  );

`ifndef NO_ASSERTIONS
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("Queue written while full.");

  a_queue_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("Queue read while empty.");

  a_kind_matches_severity: assert property (@(posedge clk) disable iff (rst)
    report.valid |-> ((report.event_kind == 1'b1) != (report.severity != 2'd0)))
    else $error("Report severity does not fit its event kind.");

  a_width_nonzero: assert property (@(posedge clk) disable iff (rst)
    report.valid |-> (report.event_width != '0))
    else $error("Report carries a zero width.");
`endif

endmodule
